### rtl/iv3alu_pkg.sv
`timescale 1ns / 1ps
// shared constants, command codes and types for the integer 3-vector alu
// no dependencies

package iv3alu_pkg;

	localparam int CW = 32;

	localparam logic [CW-1:0] MARKER = {1'b1, {(CW-1){1'b0}}};

	localparam logic [2:0] CMD_ADD   = 3'd0;
	localparam logic [2:0] CMD_SUB   = 3'd1;
	localparam logic [2:0] CMD_NEG   = 3'd2;
	localparam logic [2:0] CMD_SCALE = 3'd3;
	localparam logic [2:0] CMD_DIV   = 3'd4;
	localparam logic [2:0] CMD_DOT   = 3'd5;
	localparam logic [2:0] CMD_CROSS = 3'd6;
	// unused code, gives an all-zero result
	localparam logic [2:0] CMD_RSVD  = 3'd7;

	typedef logic [CW-1:0] comp_t;

	// data that travels beside the divider lanes
	typedef struct packed {
		logic [2:0]         cmd;
		logic               bad;
		logic [2:0]         neg;
		comp_t              dvs;
		logic [5:0][CW-1:0] p;
		logic [2:0][CW-1:0] r;
	} side_t;

endpackage

### rtl/iv3alu_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces of the vector alu
// depends on iv3alu_pkg

interface iv3alu_req_if import iv3alu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        command;
	logic signed [CW-1:0] a_x;
	logic signed [CW-1:0] a_y;
	logic signed [CW-1:0] a_z;
	logic signed [CW-1:0] b_x;
	logic signed [CW-1:0] b_y;
	logic signed [CW-1:0] b_z;
	logic signed [CW-1:0] scalar;

	modport source (output valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scalar,
		input ready);
	modport sink (input valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scalar,
		output ready);
endinterface

interface iv3alu_rsp_if import iv3alu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [CW-1:0] res_x;
	logic signed [CW-1:0] res_y;
	logic signed [CW-1:0] res_z;
	logic              invalid;

	modport source (output valid, res_x, res_y, res_z, invalid, input ready);
	modport sink (input valid, res_x, res_y, res_z, invalid, output ready);
endinterface

### rtl/int_vector3_alu_core.sv
`timescale 1ns / 1ps
// integer 3-vector alu: add, sub, negate, scale, divide, dot and cross
// depends on iv3alu_pkg and the channel interfaces in iv3alu_if.sv

// Takes one beat per clock unless the response side stalls, and returns one result
// beat per request, in order. Every command goes through the same pipeline of
// CW + 3 register stages: an input stage, a stage with the six multipliers and
// the marker checks, CW restoring-divider stages that retire one quotient bit
// each (the first also finishes dot, cross and scale), and the output register.
// A stall on the response side freezes the whole pipeline.
module int_vector3_alu_core import iv3alu_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	iv3alu_req_if.sink     req,
	iv3alu_rsp_if.source   rsp
);

	logic en;
	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// input stage
	logic              vld_s1;
	logic [2:0]        cmd_s1;
	logic [2:0][CW-1:0] a_s1;
	logic [2:0][CW-1:0] b_s1;
	comp_t             sc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= req.command;
			a_s1   <= {req.a_z, req.a_y, req.a_x};
			b_s1   <= {req.b_z, req.b_y, req.b_x};
			sc_s1  <= req.scalar;
		end
	end

	// checks, products, magnitudes
	logic  ma, mb, bad_c;
	side_t side_c;
	logic [2:0][CW-1:0] mag_c;
	comp_t x0, x1, x2, x3, x4, x5, y0, y1, y2, y3, y4, y5;

	always_comb begin
		ma = (a_s1[0] == MARKER) || (a_s1[1] == MARKER) || (a_s1[2] == MARKER);
		mb = (b_s1[0] == MARKER) || (b_s1[1] == MARKER) || (b_s1[2] == MARKER);
		case (cmd_s1)
			CMD_ADD, CMD_SUB, CMD_DOT, CMD_CROSS: bad_c = ma || mb;
			CMD_NEG, CMD_SCALE:                    bad_c = ma;
			CMD_DIV:                               bad_c = ma || (sc_s1 == '0);
			default:                               bad_c = 1'b0;
		endcase

		// multiplier operand selection
		if (cmd_s1 == CMD_CROSS) begin
			x0 = a_s1[1]; y0 = b_s1[2];
			x1 = a_s1[2]; y1 = b_s1[1];
			x2 = a_s1[2]; y2 = b_s1[0];
			x3 = a_s1[0]; y3 = b_s1[2];
			x4 = a_s1[0]; y4 = b_s1[1];
			x5 = a_s1[1]; y5 = b_s1[0];
		end else if (cmd_s1 == CMD_DOT) begin
			x0 = a_s1[0]; y0 = b_s1[0];
			x1 = '0;      y1 = '0;
			x2 = a_s1[1]; y2 = b_s1[1];
			x3 = '0;      y3 = '0;
			x4 = a_s1[2]; y4 = b_s1[2];
			x5 = '0;      y5 = '0;
		end else begin
			x0 = a_s1[0]; y0 = sc_s1;
			x1 = '0;      y1 = '0;
			x2 = a_s1[1]; y2 = sc_s1;
			x3 = '0;      y3 = '0;
			x4 = a_s1[2]; y4 = sc_s1;
			x5 = '0;      y5 = '0;
		end

		side_c.cmd  = cmd_s1;
		side_c.bad  = bad_c;
		side_c.dvs  = sc_s1[CW-1] ? comp_t'(~sc_s1 + 1'b1) : sc_s1;
		side_c.p[0] = comp_t'(x0 * y0);
		side_c.p[1] = comp_t'(x1 * y1);
		side_c.p[2] = comp_t'(x2 * y2);
		side_c.p[3] = comp_t'(x3 * y3);
		side_c.p[4] = comp_t'(x4 * y4);
		side_c.p[5] = comp_t'(x5 * y5);
		for (int i = 0; i < 3; i++) begin
			side_c.neg[i] = a_s1[i][CW-1] ^ sc_s1[CW-1];
			mag_c[i] = a_s1[i][CW-1] ? comp_t'(~a_s1[i] + 1'b1) : a_s1[i];
			case (cmd_s1)
				CMD_ADD: side_c.r[i] = comp_t'(a_s1[i] + b_s1[i]);
				CMD_SUB: side_c.r[i] = comp_t'(a_s1[i] - b_s1[i]);
				CMD_NEG: side_c.r[i] = comp_t'(~a_s1[i] + 1'b1);
				default: side_c.r[i] = '0;
			endcase
		end
	end

	// divider pipeline, index k holds the item after k quotient bits
	logic               vld_s2 [0:CW];
	side_t              side_s2 [0:CW];
	logic [2:0][CW-1:0] rem_s2 [0:CW];
	logic [2:0][CW-1:0] nq_s2 [0:CW];
	logic [CW:0]        vld_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2[0] <= 1'b0;
		end else if (en) begin
			vld_s2[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2[0] <= side_c;
			rem_s2[0]  <= '0;
			nq_s2[0]   <= mag_c;
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_div
		side_t              nxt;
		logic [2:0][CW-1:0] rem_n, nq_n;
		logic [CW:0]        sh;
		logic               ge;

		always_comb begin
			nxt = side_s2[k];
			if (k == 0) begin
				// finish the product commands
				case (side_s2[k].cmd)
					CMD_CROSS: begin
						nxt.r[0] = comp_t'(side_s2[k].p[0] - side_s2[k].p[1]);
						nxt.r[1] = comp_t'(side_s2[k].p[2] - side_s2[k].p[3]);
						nxt.r[2] = comp_t'(side_s2[k].p[4] - side_s2[k].p[5]);
					end
					CMD_DOT: begin
						nxt.r[0] = comp_t'(side_s2[k].p[0] + side_s2[k].p[2]
							+ side_s2[k].p[4]);
						nxt.r[1] = '0;
						nxt.r[2] = '0;
					end
					CMD_SCALE: begin
						nxt.r[0] = side_s2[k].p[0];
						nxt.r[1] = side_s2[k].p[2];
						nxt.r[2] = side_s2[k].p[4];
					end
					default: nxt.r = side_s2[k].r;
				endcase
			end
			for (int i = 0; i < 3; i++) begin
				sh = {rem_s2[k][i], nq_s2[k][i][CW-1]};
				ge = sh >= {1'b0, side_s2[k].dvs};
				rem_n[i] = ge ? comp_t'(sh - {1'b0, side_s2[k].dvs}) : sh[CW-1:0];
				nq_n[i]  = {nq_s2[k][i][CW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k+1] <= 1'b0;
			end else if (en) begin
				vld_s2[k+1] <= vld_s2[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s2[k+1] <= nxt;
				rem_s2[k+1]  <= rem_n;
				nq_s2[k+1]   <= nq_n;
			end
		end
	end

	for (genvar k = 0; k <= CW; k++) begin : g_vv
		assign vld_vec[k] = vld_s2[k];
	end

	// result selection and output register
	side_t              fin;
	logic [2:0][CW-1:0] res_c;

	always_comb begin
		fin = side_s2[CW];
		for (int i = 0; i < 3; i++) begin
			if (fin.bad) begin
				res_c[i] = (fin.cmd == CMD_DOT && i != 0) ? '0 : MARKER;
			end else if (fin.cmd == CMD_DIV) begin
				res_c[i] = fin.neg[i] ? comp_t'(~nq_s2[CW][i] + 1'b1) : nq_s2[CW][i];
			end else begin
				res_c[i] = fin.r[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= vld_s2[CW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.res_x   <= res_c[0];
			rsp.res_y   <= res_c[1];
			rsp.res_z   <= res_c[2];
			rsp.invalid <= fin.bad;
		end
	end

`ifndef SYNTHESIS
	a_inv_marker: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.invalid |-> rsp.res_x == MARKER)
		else $error("invalid result without marker in x");

	a_inv_yz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.invalid && rsp.res_y != MARKER |->
			rsp.res_y == '0 && rsp.res_z == '0)
		else $error("invalid dot result with nonzero y or z");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |=> $stable(vld_vec) && $stable(vld_s1))
		else $error("pipeline moved during a stall");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && cmd_s1 == CMD_DIV && sc_s1 == '0 |-> bad_c)
		else $error("divide by zero not flagged");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// self-checking bench for int_vector3_alu_core: random and directed vector ops
// depends on iv3alu_pkg, iv3alu_if.sv and the core rtl

module tb;
	import iv3alu_pkg::*;

	typedef struct packed {
		logic [2:0] command;
		comp_t a_x, a_y, a_z, b_x, b_y, b_z, scalar;
	} vec_op_t;

	typedef struct packed {
		comp_t res_x, res_y, res_z;
		logic invalid;
	} vec_res_t;

	localparam int LATENCY = CW + 3;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	iv3alu_req_if req ();
	iv3alu_rsp_if rsp ();

	int_vector3_alu_core dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	vec_op_t pending_ops[$];
	vec_res_t expected_res[$];
	int errors;
	bit quiet_mode;
	bit stim_done;
	bit req_taken;
	int src_gap, snk_gap, idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit has_marker(comp_t x, comp_t y, comp_t z);
		return x == MARKER || y == MARKER || z == MARKER;
	endfunction

	function automatic comp_t quot_trunc(comp_t n, comp_t d);
		comp_t mn, md, q;
		mn = n[CW-1] ? -n : n;
		md = d[CW-1] ? -d : d;
		q = mn / md;
		return (n[CW-1] ^ d[CW-1]) ? -q : q;
	endfunction

	function automatic vec_res_t vector_result(vec_op_t op);
		vec_res_t r;
		bit bad_a, bad_b, bad;
		bad_a = has_marker(op.a_x, op.a_y, op.a_z);
		bad_b = has_marker(op.b_x, op.b_y, op.b_z);
		r = '0;
		bad = 1'b0;
		case (op.command)
			CMD_ADD: begin
				bad = bad_a | bad_b;
				r.res_x = op.a_x + op.b_x;
				r.res_y = op.a_y + op.b_y;
				r.res_z = op.a_z + op.b_z;
			end
			CMD_SUB: begin
				bad = bad_a | bad_b;
				r.res_x = op.a_x - op.b_x;
				r.res_y = op.a_y - op.b_y;
				r.res_z = op.a_z - op.b_z;
			end
			CMD_NEG: begin
				bad = bad_a;
				r.res_x = -op.a_x;
				r.res_y = -op.a_y;
				r.res_z = -op.a_z;
			end
			CMD_SCALE: begin
				bad = bad_a;
				r.res_x = op.a_x * op.scalar;
				r.res_y = op.a_y * op.scalar;
				r.res_z = op.a_z * op.scalar;
			end
			CMD_DIV: begin
				bad = bad_a || op.scalar == '0;
				if (!bad) begin
					r.res_x = quot_trunc(op.a_x, op.scalar);
					r.res_y = quot_trunc(op.a_y, op.scalar);
					r.res_z = quot_trunc(op.a_z, op.scalar);
				end
			end
			CMD_DOT: begin
				// dot keeps y and z at zero even when invalid
				if (bad_a | bad_b) begin
					r.res_x = MARKER;
					r.invalid = 1'b1;
				end else begin
					r.res_x = op.a_x * op.b_x + op.a_y * op.b_y + op.a_z * op.b_z;
				end
			end
			CMD_CROSS: begin
				bad = bad_a | bad_b;
				r.res_x = op.a_y * op.b_z - op.a_z * op.b_y;
				r.res_y = op.a_z * op.b_x - op.a_x * op.b_z;
				r.res_z = op.a_x * op.b_y - op.a_y * op.b_x;
			end
			default: r = '0;
		endcase
		if (bad) begin
			r.res_x = MARKER;
			r.res_y = MARKER;
			r.res_z = MARKER;
			r.invalid = 1'b1;
		end
		return r;
	endfunction

	function automatic comp_t pick_comp();
		case ($urandom_range(0, 9))
			0: return MARKER;
			1: return comp_t'($urandom_range(0, 6)) - 3;
			2: return {1'b0, {(CW-1){1'b1}}};
			3: return MARKER + comp_t'($urandom_range(1, 3));
			4: return comp_t'($urandom_range(0, 2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_op_t rand_op();
		vec_op_t op;
		op.command = 3'($urandom_range(0, 7));
		op.a_x = pick_comp();
		op.a_y = pick_comp();
		op.a_z = pick_comp();
		op.b_x = pick_comp();
		op.b_y = pick_comp();
		op.b_z = pick_comp();
		op.scalar = ($urandom_range(0, 9) == 0) ? '0 : pick_comp();
		return op;
	endfunction

	task automatic add_op(logic [2:0] cmd, comp_t ax, comp_t ay, comp_t az,
		comp_t bx, comp_t by, comp_t bz, comp_t s);
		vec_op_t op;
		op = '{cmd, ax, ay, az, bx, by, bz, s};
		pending_ops.push_back(op);
	endtask

	initial begin
		comp_t mx, mn1;
		mx = {1'b0, {(CW-1){1'b1}}};
		mn1 = MARKER + 1;
		errors = 0;
		quiet_mode = 1'b0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		add_op(CMD_ADD, mx, mn1, 0, 1, -1, 0, 5);
		add_op(CMD_ADD, MARKER, 1, 2, 3, 4, 5, 0);
		add_op(CMD_SUB, mn1, mx, 7, 1, -1, -7, 0);
		add_op(CMD_SUB, 1, 2, 3, 4, MARKER, 6, 0);
		add_op(CMD_NEG, mx, mn1, 0, MARKER, MARKER, MARKER, MARKER);
		add_op(CMD_NEG, 1, MARKER, 3, 0, 0, 0, 0);
		add_op(CMD_SCALE, mx, -5, 3, 0, 0, 0, MARKER);
		add_op(CMD_SCALE, 1, 2, MARKER, 0, 0, 0, 3);
		add_op(CMD_DIV, 7, -7, mn1, MARKER, 0, 0, 2);
		add_op(CMD_DIV, mx, -9, 9, 0, 0, 0, -4);
		add_op(CMD_DIV, 1, 2, 3, 0, 0, 0, 0);
		add_op(CMD_DIV, mn1, mx, 1, 0, 0, 0, MARKER);
		add_op(CMD_DIV, 5, 6, 7, 0, 0, 0, -1);
		add_op(CMD_DIV, MARKER, 6, 7, 0, 0, 0, 3);
		add_op(CMD_DOT, mx, mx, mx, mx, mn1, 2, 0);
		add_op(CMD_DOT, 1, 2, 3, 4, 5, MARKER, 0);
		add_op(CMD_CROSS, mx, mn1, 3, -4, 5, mx, 0);
		add_op(CMD_CROSS, 1, 2, 3, MARKER, 5, 6, 0);
		add_op(CMD_RSVD, mx, mn1, MARKER, 1, 2, 3, 4);
		add_op(CMD_RSVD, 0, 0, 0, 0, 0, 0, 0);
		add_op(CMD_ADD, '1, '1, '1, '1, '1, '1, '1);
		for (int i = 0; i < 750; i++) pending_ops.push_back(rand_op());
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_ops.size() == 0 && !req.valid);
		stim_done = 1'b1;
	end

	// quiet tail: no idling once few items remain
	always @(negedge clk) quiet_mode <= pending_ops.size() < 60;

	// request driver and response-side ready
	initial begin
		req.valid = 1'b0;
		{req.command, req.a_x, req.a_y, req.a_z, req.b_x, req.b_y, req.b_z, req.scalar} = '0;
		rsp.ready = 1'b0;
		src_gap = 0;
		snk_gap = 0;
		req_taken = 1'b0;
	end

	// remember whether the request beat went through at the last rising edge
	always @(posedge clk) req_taken <= req.valid && req.ready;

	always @(negedge clk) begin
		vec_op_t op;
		if (arst_n) begin
			if (req.valid && !req_taken) begin
				// hold the beat
			end else if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				req.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				op = pending_ops.pop_front();
				req.valid <= 1'b1;
				req.command <= op.command;
				req.a_x <= op.a_x;
				req.a_y <= op.a_y;
				req.a_z <= op.a_z;
				req.b_x <= op.b_x;
				req.b_y <= op.b_y;
				req.b_z <= op.b_z;
				req.scalar <= op.scalar;
				if (!quiet_mode && $urandom_range(0, 7) == 0)
					src_gap <= $urandom_range(1, 13);
			end else begin
				req.valid <= 1'b0;
			end
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (!quiet_mode && $urandom_range(0, 7) == 0)
					snk_gap <= $urandom_range(1, 13);
			end
		end
	end

	// monitor: predict on accepted requests, check accepted responses
	always @(posedge clk) begin
		vec_op_t op;
		vec_res_t got, want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				op = '{req.command, req.a_x, req.a_y, req.a_z, req.b_x, req.b_y,
					req.b_z, req.scalar};
				expected_res.push_back(vector_result(op));
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.res_x, rsp.res_y, rsp.res_z, rsp.invalid};
				if (expected_res.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, got);
					errors++;
				end else begin
					want = expected_res.pop_front();
					if (got.res_x !== want.res_x) begin
						$display("%0t: res_x expected %h actual %h", $time, want.res_x, got.res_x);
						errors++;
					end
					if (got.res_y !== want.res_y) begin
						$display("%0t: res_y expected %h actual %h", $time, want.res_y, got.res_y);
						errors++;
					end
					if (got.res_z !== want.res_z) begin
						$display("%0t: res_z expected %h actual %h", $time, want.res_z, got.res_z);
						errors++;
					end
					if (got.invalid !== want.invalid) begin
						$display("%0t: invalid expected %b actual %b", $time, want.invalid,
							got.invalid);
						errors++;
					end
				end
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		fork
			begin
				wait (idle_cycles >= STALL_LIMIT);
				$display("CHECKS FAILED");
			end
			begin
				wait (stim_done && expected_res.size() == 0);
				repeat (LATENCY + 5) @(posedge clk);
				if (errors == 0 && expected_res.size() == 0)
					$display("ALL CHECKS PASSED");
				else
					$display("CHECKS FAILED");
			end
		join_any
		$finish;
	end

endmodule

### filelist.f
rtl/iv3alu_pkg.sv
rtl/iv3alu_if.sv
rtl/int_vector3_alu_core.sv
dv/tb.sv
